FILE: rtl/core/fsn_utf8_pkg.sv
package fsn_utf8_pkg;

  // symbol slots: eight name bytes, the dot, three extension bytes, the terminator
  localparam int unsigned NameLen  = 8;
  localparam int unsigned ExtLen   = 3;
  localparam logic [3:0]  SymDot   = 4'd8;
  localparam logic [3:0]  SymExt0  = 4'd9;
  localparam logic [3:0]  SymTerm  = 4'd12;

  localparam logic [7:0]  ChSpace  = 8'h20;
  localparam logic [7:0]  ChDot    = 8'h2e;
  localparam logic [7:0]  ChQuery  = 8'h3f;
  localparam logic [7:0]  ChKanji  = 8'h05;
  localparam logic [7:0]  ChE5     = 8'he5;
  localparam logic [7:0]  ChDel    = 8'h7f;

  typedef struct packed {
    logic [63:0] name_chars;
    logic [23:0] ext_chars;
    logic [15:0] buffer_size;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       too_small;
  } result_t;

  // utf-8 sequence of one character: length and up to three bytes
  typedef struct packed {
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } seq_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic count;
    logic err;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_end;
    logic fits;
    logic out_room;
  } dp_sts_t;

  // cp1252 0x80-0x9f
  function automatic seq_t upper_seq(input logic [4:0] c);
    seq_t s;
    s = '{len: 2'd1, b0: ChQuery, b1: 8'h00, b2: 8'h00};
    unique case (c)
      5'h00: s = '{2'd3, 8'he2, 8'h82, 8'hac};
      5'h02: s = '{2'd3, 8'he2, 8'h80, 8'h9a};
      5'h03: s = '{2'd2, 8'hc6, 8'h92, 8'h00};
      5'h04: s = '{2'd3, 8'he2, 8'h80, 8'h9e};
      5'h05: s = '{2'd3, 8'he2, 8'h80, 8'ha6};
      5'h06: s = '{2'd3, 8'he2, 8'h80, 8'ha0};
      5'h07: s = '{2'd3, 8'he2, 8'h80, 8'ha1};
      5'h08: s = '{2'd2, 8'hcb, 8'h86, 8'h00};
      5'h09: s = '{2'd3, 8'he2, 8'h80, 8'hb0};
      5'h0a: s = '{2'd2, 8'hc5, 8'ha0, 8'h00};
      5'h0b: s = '{2'd3, 8'he2, 8'h80, 8'hb9};
      5'h0c: s = '{2'd2, 8'hc5, 8'h92, 8'h00};
      5'h0e: s = '{2'd2, 8'hc5, 8'hbd, 8'h00};
      5'h11: s = '{2'd3, 8'he2, 8'h80, 8'h98};
      5'h12: s = '{2'd3, 8'he2, 8'h80, 8'h99};
      5'h13: s = '{2'd3, 8'he2, 8'h80, 8'h9c};
      5'h14: s = '{2'd3, 8'he2, 8'h80, 8'h9d};
      5'h15: s = '{2'd3, 8'he2, 8'h80, 8'ha2};
      5'h16: s = '{2'd3, 8'he2, 8'h80, 8'h93};
      5'h17: s = '{2'd3, 8'he2, 8'h80, 8'h94};
      5'h18: s = '{2'd2, 8'hcb, 8'h9c, 8'h00};
      5'h19: s = '{2'd3, 8'he2, 8'h84, 8'ha2};
      5'h1a: s = '{2'd2, 8'hc5, 8'ha1, 8'h00};
      5'h1b: s = '{2'd3, 8'he2, 8'h80, 8'hba};
      5'h1c: s = '{2'd2, 8'hc5, 8'h93, 8'h00};
      5'h1e: s = '{2'd2, 8'hc5, 8'hbe, 8'h00};
      5'h1f: s = '{2'd2, 8'hc5, 8'hb8, 8'h00};
      default: s = '{2'd1, ChQuery, 8'h00, 8'h00};
    endcase
    return s;
  endfunction

  // full cp1252 to utf-8 mapping of one byte
  function automatic seq_t cp_seq(input logic [7:0] c);
    seq_t s;
    s = '{len: 2'd1, b0: ChQuery, b1: 8'h00, b2: 8'h00};
    if (c < 8'h20 || c == ChDel) begin
      s = '{2'd1, ChQuery, 8'h00, 8'h00};
    end else if (c < ChDel) begin
      s = '{2'd1, c, 8'h00, 8'h00};
    end else if (c < 8'ha0) begin
      s = upper_seq(c[4:0]);
    end else if (c < 8'hc0) begin
      s = '{2'd2, 8'hc2, c, 8'h00};
    end else begin
      s = '{2'd2, 8'hc3, {2'b10, c[5:0]}, 8'h00};
    end
    return s;
  endfunction

endpackage

FILE: rtl/core/fat_short_name_to_utf8.sv
// FAT 8.3 short name to UTF-8 converter. One beat in carries the 11 name
// bytes and the buffer size; the result channel then carries the UTF-8
// bytes one per beat, ending in a zero byte with last_byte set, or a single
// beat with too_small and last_byte set when the output would not fit.
// An item is loaded, then a sizing pass walks the twelve symbol slots plus
// terminator, the size is checked, and an emit pass steps over each skipped
// slot and sends each output byte (up to 35); an output byte waits while the
// result channel stalls. The single slot walker in the datapath does both
// passes.
// The next item is taken once the last byte sits in the output register.
module fat_short_name_to_utf8 (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  fsn_utf8_pkg::item_t   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output fsn_utf8_pkg::result_t result
);

  fsn_utf8_pkg::dp_cmd_t cmd;
  fsn_utf8_pkg::dp_sts_t sts;
  logic                  busy;

  assign item_stall = busy;

  fsn_utf8_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .busy       (busy),
    .sts        (sts),
    .cmd        (cmd)
  );

  fsn_utf8_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: rtl/core/fsn_utf8_dp.sv
module fsn_utf8_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  fsn_utf8_pkg::dp_cmd_t cmd,
  output fsn_utf8_pkg::dp_sts_t sts,
  input  fsn_utf8_pkg::item_t   item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output fsn_utf8_pkg::result_t result
);

  logic [7:0]  name_b [fsn_utf8_pkg::NameLen];
  logic [7:0]  ext_b  [fsn_utf8_pkg::ExtLen];
  logic [15:0] cap;
  logic [3:0]  idx;
  logic [1:0]  sub;
  logic [5:0]  count;

  logic [3:0]  nlen;
  logic [1:0]  elen;
  logic [7:0]  sym_char;
  logic        sym_valid;
  fsn_utf8_pkg::seq_t seq;
  logic [7:0]  seq_byte;
  logic        out_room;
  logic        emit_fire;
  logic        sym_done;
  logic [3:0]  ext_off;

  // trimmed lengths of name and extension
  always_comb begin
    nlen = 4'd0;
    for (int i = 0; i < fsn_utf8_pkg::NameLen; i++) begin
      if (name_b[i] != fsn_utf8_pkg::ChSpace) nlen = 4'(i + 1);
    end
    elen = 2'd0;
    for (int i = 0; i < fsn_utf8_pkg::ExtLen; i++) begin
      if (ext_b[i] != fsn_utf8_pkg::ChSpace) elen = 2'(i + 1);
    end
  end

  // character and presence of the current symbol slot
  always_comb begin
    ext_off   = idx - fsn_utf8_pkg::SymExt0;
    sym_char  = fsn_utf8_pkg::ChDot;
    sym_valid = 1'b0;
    if (idx < fsn_utf8_pkg::SymDot) begin
      sym_char  = name_b[idx[2:0]];
      if (idx == 4'd0 && sym_char == fsn_utf8_pkg::ChKanji) sym_char = fsn_utf8_pkg::ChE5;
      sym_valid = idx < nlen;
    end else if (idx == fsn_utf8_pkg::SymDot) begin
      sym_char  = fsn_utf8_pkg::ChDot;
      sym_valid = elen != 2'd0;
    end else if (idx < fsn_utf8_pkg::SymTerm) begin
      sym_char  = ext_b[ext_off[1:0]];
      sym_valid = ext_off < {2'b00, elen};
    end else begin
      sym_char  = 8'h00;
      sym_valid = 1'b1;
    end
  end

  // utf-8 bytes of the current symbol, terminator sent as a single zero
  always_comb begin
    if (idx == fsn_utf8_pkg::SymTerm) seq = '{2'd1, 8'h00, 8'h00, 8'h00};
    else seq = fsn_utf8_pkg::cp_seq(sym_char);
    unique case (sub)
      2'd0:    seq_byte = seq.b0;
      2'd1:    seq_byte = seq.b1;
      default: seq_byte = seq.b2;
    endcase
  end

  assign out_room  = !result_valid || !result_stall;
  assign emit_fire = cmd.emit && sym_valid && out_room;
  assign sym_done  = (sub + 2'd1) == seq.len;

  assign sts.idx_end  = idx == fsn_utf8_pkg::SymTerm;
  assign sts.fits     = {10'd0, count} <= cap;
  assign sts.out_room = out_room;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < fsn_utf8_pkg::NameLen; i++) name_b[i] <= item.name_chars[8*i +: 8];
      for (int i = 0; i < fsn_utf8_pkg::ExtLen; i++) ext_b[i] <= item.ext_chars[8*i +: 8];
      cap <= item.buffer_size;
    end
  end

  // slot walk: sizing pass then emit pass
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= 4'd0;
      sub   <= 2'd0;
      count <= 6'd0;
    end else if (cmd.load) begin
      idx   <= 4'd0;
      sub   <= 2'd0;
      count <= 6'd0;
    end else if (cmd.count) begin
      if (sym_valid) count <= count + {4'd0, seq.len};
      idx <= sts.idx_end ? 4'd0 : idx + 4'd1;
    end else if (cmd.emit) begin
      if (!sym_valid) begin
        idx <= idx + 4'd1;
      end else if (emit_fire) begin
        if (sym_done) begin
          sub <= 2'd0;
          idx <= sts.idx_end ? 4'd0 : idx + 4'd1;
        end else begin
          sub <= sub + 2'd1;
        end
      end
    end
  end

  // output register: filled by a new beat, held while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit_fire || (cmd.err && out_room) || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err && out_room) begin
      result <= '{out_byte: 8'h00, last_byte: 1'b1, too_small: 1'b1};
    end else if (emit_fire) begin
      result <= '{out_byte: seq_byte, last_byte: sts.idx_end, too_small: 1'b0};
    end
  end

endmodule

FILE: rtl/core/fsn_utf8_ctrl.sv
module fsn_utf8_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  busy,
  input  fsn_utf8_pkg::dp_sts_t sts,
  output fsn_utf8_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    COUNT,
    DECIDE,
    EMIT
  } state_t;

  state_t state, state_next;

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        cmd.load = item_valid;
        if (item_valid) state_next = COUNT;
      end
      COUNT: begin
        cmd.count = 1'b1;
        if (sts.idx_end) state_next = DECIDE;
      end
      DECIDE: begin
        if (!sts.fits) begin
          cmd.err = 1'b1;
          if (sts.out_room) state_next = IDLE;
        end else begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        cmd.emit = 1'b1;
        if (sts.idx_end && sts.out_room) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= state_next != IDLE;
    end
  end

endmodule
